/* design/uvs_pkg.sv */
package uvs_pkg;

	localparam int ONE_Q14 = 16384;
	localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
	localparam logic signed [33:0] K_Q30 = 34'sh026DD3B6A;
	localparam int ATAN_ENTRIES = 24;

	// register indexes
	localparam logic [2:0] REG_SEGMENTS = 3'd0;
	localparam logic [2:0] REG_RINGS    = 3'd1;
	localparam logic [2:0] REG_RED      = 3'd2;
	localparam logic [2:0] REG_GREEN    = 3'd3;
	localparam logic [2:0] REG_BLUE     = 3'd4;

	typedef struct packed {
		logic [10:0] ring_row;
		logic [10:0] segment_column;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [14:0] color_red;
		logic [14:0] color_green;
		logic [14:0] color_blue;
		logic [14:0] tex_u;
		logic [14:0] tex_v;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [14:0] data;
	} cfg_item_t;

	// arctangent table, Q2.30 radians
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0: r = 34'sh03243F6A8;
			5'd1: r = 34'sh01DAC6705;
			5'd2: r = 34'sh00FADBAFC;
			5'd3: r = 34'sh007F56EA6;
			5'd4: r = 34'sh003FEAB76;
			5'd5: r = 34'sh001FFD55B;
			5'd6: r = 34'sh000FFFAAA;
			5'd7: r = 34'sh0007FFF55;
			5'd8: r = 34'sh0003FFFEA;
			5'd9: r = 34'sh0001FFFFD;
			5'd10: r = 34'sh0000FFFFF;
			5'd11: r = 34'sh00007FFFF;
			5'd12: r = 34'sh00003FFFF;
			5'd13: r = 34'sh00001FFFF;
			5'd14: r = 34'sh00000FFFF;
			5'd15: r = 34'sh000007FFF;
			5'd16: r = 34'sh000003FFF;
			5'd17: r = 34'sh000001FFF;
			5'd18: r = 34'sh000000FFF;
			5'd19: r = 34'sh0000007FF;
			5'd20: r = 34'sh0000003FF;
			5'd21: r = 34'sh0000001FF;
			5'd22: r = 34'sh0000000FF;
			5'd23: r = 34'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/uvs_cordic.sv */
// Pipelined sine/cosine of a 32-bit full-turn phase, Q2.30 results.
// Stages: quadrant reduction, radian scaling, rotation seed, then one per rotation; en advances all stages.
module uvs_cordic #(
	parameter int STEPS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic [31:0] phase,
	output logic signed [33:0] sin_q30,
	output logic signed [33:0] cos_q30
);
	import uvs_pkg::*;

	localparam int NS = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

	logic [1:0]  quad_s1;
	logic [29:0] mag_s1;
	logic        neg_s1;
	logic [62:0] prod_s2;
	logic [1:0]  quad_s2;
	logic        neg_s2;
	logic signed [33:0] x_s [NS+1];
	logic signed [33:0] y_s [NS+1];
	logic signed [33:0] z_s [NS+1];
	logic [1:0]  q_s [NS+1];
	logic [31:0] t;
	logic signed [30:0] r;
	logic signed [33:0] zr;

	assign t = phase + 32'h2000_0000;
	assign r = $signed({1'b0, t[29:0]}) - 31'sh2000_0000;

	// quadrant reduction and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= t[31:30];
			neg_s1  <= r[30];
			mag_s1  <= r[30] ? 30'(-r) : 30'(r);
		end
	end

	// scale to radians
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 63'(mag_s1) * 63'(PI_Q30);
			quad_s2 <= quad_s1;
			neg_s2  <= neg_s1;
		end
	end

	assign zr = $signed({2'b00, 32'((prod_s2 + 63'h4000_0000) >> 31)});

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= K_Q30;
			y_s[0] <= '0;
			z_s[0] <= neg_s2 ? -zr : zr;
			q_s[0] <= quad_s2;
		end
	end

	// one rotation per stage
	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(5'(i));
				end
				q_s[i+1] <= q_s[i];
			end
		end
	end

	// quadrant restore
	always_comb begin
		case (q_s[NS])
			2'd0: begin sin_q30 = y_s[NS];  cos_q30 = x_s[NS];  end
			2'd1: begin sin_q30 = x_s[NS];  cos_q30 = -y_s[NS]; end
			2'd2: begin sin_q30 = -y_s[NS]; cos_q30 = -x_s[NS]; end
			default: begin sin_q30 = -x_s[NS]; cos_q30 = y_s[NS]; end
		endcase
	end
endmodule

/* design/uvs_divider.sv */
// Pipelined restoring division: quotient of num by den, one bit per stage.
// Every stage advances only while en is high.
module uvs_divider #(
	parameter int NW = 27,
	parameter int DW = 17,
	parameter int QW = 15
) (
	input  logic clk,
	input  logic en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	logic [NW-1:0]  n_s [1:QW-1];
	logic [DW-1:0]  d_s [1:QW-1];
	logic [DW:0]    rem_s [1:QW-1];
	logic [QW-1:0]  q_s [1:QW];

	// quotient bit QW-1-i decided at stage i; top num bits are known to give zero quotient
	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [NW-1:0] n_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [DW:0]   pre;
		logic [DW+1:0] trial;
		if (i == 0) begin : g_head
			assign n_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign pre = (DW+1)'(num >> QW);
		end else begin : g_body
			assign n_in = n_s[i];
			assign d_in = d_s[i];
			assign q_in = q_s[i];
			assign pre = rem_s[i];
		end
		assign trial = {pre, n_in[QW-1-i]} - {2'b00, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[DW+1])
					q_s[i+1] <= q_in | (QW'(1) << (QW-1-i));
				else
					q_s[i+1] <= q_in;
			end
		end
		// operands and partial remainder move on to the next bit
		if (i < QW-1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					n_s[i+1] <= n_in;
					d_s[i+1] <= d_in;
					if (!trial[DW+1])
						rem_s[i+1] <= trial[DW:0];
					else
						rem_s[i+1] <= (DW+1)'({pre, n_in[QW-1-i]});
				end
			end
		end
	end

	assign quo = q_s[QW];
endmodule

/* design/uv_sphere_vertex_generator_core.sv */
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | uvs_pkg::in_item_t
// out     | output    | out_valid/stall  | uvs_pkg::out_item_t
// cfg     | input     | cfg_valid/ready  | uvs_pkg::cfg_item_t
// One vertex per cycle sustained while no held result stalls the output. Stages: index clamp,
// divider bits, CORDIC, product and rounding, then the output register.
// Reset clears valid bits and colors and sets 32 segments, 16 rings; cfg_ready is always high.
// A stall freezes the whole pipeline; in_stall follows out_stall while the output holds.
module uv_sphere_vertex_generator_core #(
	parameter int ANGLE_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  uvs_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output uvs_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  uvs_pkg::cfg_item_t cfg_data
);
	import uvs_pkg::*;

	localparam int NS  = (ANGLE_STEPS < ATAN_ENTRIES) ? ANGLE_STEPS : ATAN_ENTRIES;
	localparam int LAT = 1 + 15 + NS + 3 + 2;

	logic [10:0] seg_q, rng_q;
	logic [14:0] red_q, green_q, blue_q;
	logic [10:0] seg_c, rng_c;
	logic en;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= 11'd32;
			rng_q <= 11'd16;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_data.index)
				REG_SEGMENTS: seg_q <= cfg_data.data[10:0];
				REG_RINGS:    rng_q <= cfg_data.data[10:0];
				REG_RED:      red_q <= cfg_data.data;
				REG_GREEN:    green_q <= cfg_data.data;
				REG_BLUE:     blue_q <= cfg_data.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		seg_c = (seg_q == 0) ? 11'd1 : ((seg_q > 11'd1024) ? 11'd1024 : seg_q);
		rng_c = (rng_q == 0) ? 11'd1 : ((rng_q > 11'd1024) ? 11'd1024 : rng_q);
	end

	// the pipeline advances unless a finished result is held
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: clamp indices, form numerators
	logic [26:0] nu_s1, nv_s1;
	logic [10:0] seg_s1, rng_s1;
	logic [10:0] row, col;
	assign row = (in_data.ring_row > rng_c) ? rng_c : in_data.ring_row;
	assign col = (in_data.segment_column > seg_c) ? seg_c : in_data.segment_column;
	always_ff @(posedge clk) begin
		if (en) begin
			nu_s1 <= {col, 14'd0} + 27'(seg_c >> 1);
			nv_s1 <= {row, 14'd0} + 27'(rng_c >> 1);
			seg_s1 <= seg_c;
			rng_s1 <= rng_c;
		end
	end

	logic [14:0] u_d, v_d;
	uvs_divider #(.NW(27), .DW(17), .QW(15)) u_div_u (
		.clk(clk), .en(en), .num(nu_s1), .den(17'(seg_s1)), .quo(u_d)
	);
	uvs_divider #(.NW(27), .DW(17), .QW(15)) u_div_v (
		.clk(clk), .en(en), .num(nv_s1), .den(17'(rng_s1)), .quo(v_d)
	);

	logic signed [33:0] st, ct, sp, cp;
	uvs_cordic #(.STEPS(ANGLE_STEPS)) u_cor_t (
		.clk(clk), .en(en), .phase(32'(v_d) << 17), .sin_q30(st), .cos_q30(ct)
	);
	uvs_cordic #(.STEPS(ANGLE_STEPS)) u_cor_p (
		.clk(clk), .en(en), .phase(32'(u_d) << 18), .sin_q30(sp), .cos_q30(cp)
	);

	// u and v ride alongside the CORDIC and product stages
	localparam int UVD = NS + 3 + 2;
	logic [14:0] u_dl [1:UVD];
	logic [14:0] v_dl [1:UVD];
	for (genvar k = 0; k < UVD; k++) begin : g_uv
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					u_dl[1] <= u_d;
					v_dl[1] <= v_d;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					u_dl[k+1] <= u_dl[k];
					v_dl[k+1] <= v_dl[k];
				end
			end
		end
	end

	// products
	logic signed [67:0] px_p, pz_p;
	logic signed [33:0] ct_p;
	always_ff @(posedge clk) begin
		if (en) begin
			px_p <= st * cp;
			pz_p <= st * sp;
			ct_p <= ct;
		end
	end

	// rounding and clamp
	function automatic logic signed [15:0] clamp_unit(input logic signed [51:0] v);
		if (v > 52'sd16384) return 16'sd16384;
		if (v < -52'sd16384) return -16'sd16384;
		return 16'(v);
	endfunction

	logic signed [67:0] rx, rz;
	logic signed [33:0] ry;
	assign rx = (px_p + (68'sd1 <<< 45)) >>> 46;
	assign rz = (pz_p + (68'sd1 <<< 45)) >>> 46;
	assign ry = (ct_p + 34'sd32768) >>> 16;

	logic signed [15:0] x_r, y_r, z_r;
	always_ff @(posedge clk) begin
		if (en) begin
			x_r <= clamp_unit(52'(rx));
			y_r <= clamp_unit(52'(ry));
			z_r <= clamp_unit(52'(rz));
		end
	end

	// valid shift line
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// output register
	logic grad;
	assign grad = (red_q == 0) && (green_q == 0) && (blue_q == 0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= vld_q[LAT-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.pos_x <= x_r;
			out_data.pos_y <= y_r;
			out_data.pos_z <= z_r;
			out_data.tex_u <= u_dl[UVD];
			out_data.tex_v <= v_dl[UVD];
			if (grad) begin
				out_data.color_red <= u_dl[UVD];
				out_data.color_green <= v_dl[UVD];
				out_data.color_blue <= '0;
			end else begin
				out_data.color_red <= (red_q > 15'd16384) ? 15'd16384 : red_q;
				out_data.color_green <= (green_q > 15'd16384) ? 15'd16384 : green_q;
				out_data.color_blue <= (blue_q > 15'd16384) ? 15'd16384 : blue_q;
			end
		end
	end

	// assertions
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held result changed");
	a_install: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.tex_u <= 15'd16384 && out_data.tex_v <= 15'd16384)
		else $error("texture out of range");
endmodule

/* tb/uv_sphere_vertex_generator_core_test.sv */
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_core_test;
	import uvs_pkg::*;

	localparam int PIPE_LATENCY = 1 + 15 + 16 + 3 + 2 + 1;
	localparam longint PI_RAD_Q30 = 64'hC90FDAA2;
	localparam longint GAIN_Q30 = 64'h26DD3B6A;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_item_t cfg_data = '0;

	uv_sphere_vertex_generator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the configuration registers
	logic [10:0] seg_reg, ring_reg;
	logic [14:0] red_reg, green_reg, blue_reg;

	out_item_t vertex_queue[$];
	int mismatch_count = 0;
	int vertex_count = 0;
	int cfg_writes = 0;
	bit idle_enable = 1'b1;

	const longint arctan_q30[16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

	// rotation CORDIC on a full-turn phase, Q2.30 outputs
	task automatic phase_sin_cos(input logic [31:0] phase, output longint s, output longint c);
		logic [31:0] t;
		longint r, z, x, y, dx, dy;
		longint unsigned mag;
		t = phase + 32'h2000_0000;
		r = longint'({2'b00, t[29:0]}) - 64'sh2000_0000;
		mag = (r < 0) ? -r : r;
		z = longint'((mag * PI_RAD_Q30 + 64'h4000_0000) >> 31);
		if (r < 0)
			z = -z;
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_q30[i];
			end else begin
				x += dx; y -= dy; z += arctan_q30[i];
			end
		end
		case (t[31:30])
			2'd0: begin s = y; c = x; end
			2'd1: begin s = x; c = -y; end
			2'd2: begin s = -y; c = -x; end
			default: begin s = -x; c = y; end
		endcase
	endtask

	function automatic longint unit_clamp(input longint v);
		if (v > ONE_Q14)
			return ONE_Q14;
		if (v < -ONE_Q14)
			return -ONE_Q14;
		return v;
	endfunction

	function automatic longint count_clamp(input logic [10:0] c);
		if (c == 0)
			return 1;
		if (c > 1024)
			return 1024;
		return c;
	endfunction

	function automatic logic [14:0] color_clamp(input logic [14:0] c);
		return (c > ONE_Q14) ? 15'(ONE_Q14) : c;
	endfunction

	task automatic predict_vertex(input in_item_t pt, output out_item_t vx);
		longint seg, rng, row, col, u, v, st, ct, sp, cp;
		logic [31:0] theta, phi;
		seg = count_clamp(seg_reg);
		rng = count_clamp(ring_reg);
		row = pt.ring_row;
		col = pt.segment_column;
		if (row > rng)
			row = rng;
		if (col > seg)
			col = seg;
		u = (col * ONE_Q14 + seg / 2) / seg;
		v = (row * ONE_Q14 + rng / 2) / rng;
		theta = 32'(v << 17);
		phi = 32'(u << 18);
		phase_sin_cos(theta, st, ct);
		phase_sin_cos(phi, sp, cp);
		vx.pos_x = 16'(unit_clamp((st * cp + (64'sd1 <<< 45)) >>> 46));
		vx.pos_y = 16'(unit_clamp((ct + 32768) >>> 16));
		vx.pos_z = 16'(unit_clamp((st * sp + (64'sd1 <<< 45)) >>> 46));
		if (red_reg == 0 && green_reg == 0 && blue_reg == 0) begin
			vx.color_red = 15'(u);
			vx.color_green = 15'(v);
			vx.color_blue = '0;
		end else begin
			vx.color_red = color_clamp(red_reg);
			vx.color_green = color_clamp(green_reg);
			vx.color_blue = color_clamp(blue_reg);
		end
		vx.tex_u = 15'(u);
		vx.tex_v = 15'(v);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [14:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= '{index: idx, data: value};
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SEGMENTS: seg_reg = value[10:0];
			REG_RINGS: ring_reg = value[10:0];
			REG_RED: red_reg = value;
			REG_GREEN: green_reg = value;
			REG_BLUE: blue_reg = value;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// close the input, wait for all vertices to drain, then let the pipeline settle
	task automatic drain_pipeline;
		@(negedge clk);
		in_valid <= 1'b0;
		while (vertex_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	// one input transfer; the predictor runs when it is accepted, valid stays up
	// so that the next transfer can follow in the very next cycle
	task automatic send_point(input logic [10:0] row, input logic [10:0] col,
			input bit has_expect, input out_item_t expect_vx);
		out_item_t vx;
		@(negedge clk);
		while (idle_enable && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{ring_row: row, segment_column: col};
		do
			@(posedge clk);
		while (in_stall);
		predict_vertex('{ring_row: row, segment_column: col}, vx);
		if (has_expect && vx !== expect_vx) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("typed vertex row=%0d col=%0d: expected %p predicted %p",
					row, col, expect_vx, vx);
		end
		vertex_queue = {vertex_queue, vx};
	endtask

	// output side: random stall, checking against oldest prediction
	always @(negedge clk) begin
		out_stall <= idle_enable && ($urandom_range(99) < 9);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected vertex %p", out_data);
			end else begin
				if (out_data !== vertex_queue[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("vertex mismatch: expected %p got %p",
							vertex_queue[0], out_data);
				end
				void'(vertex_queue.pop_front());
				vertex_count++;
			end
		end
	end

	typedef struct {
		logic [10:0] row;
		logic [10:0] col;
		bit known;
		out_item_t vx;
	} point_row_t;

	// directed points at reset config: 32 segments, 16 rings, gradient color
	point_row_t directed_points[] = '{
		'{11'd0, 11'd0, 1'b1, '{16'sd0, 16'sd16384, 16'sd0, 15'd0, 15'd0, 15'd0,
			15'd0, 15'd0}},
		'{11'd16, 11'd0, 1'b1, '{16'sd0, -16'sd16384, 16'sd0, 15'd0, 15'd16384,
			15'd0, 15'd0, 15'd16384}},
		'{11'd2047, 11'd2047, 1'b0, '0},
		'{11'd8, 11'd0, 1'b0, '0},
		'{11'd8, 11'd8, 1'b0, '0},
		'{11'd8, 11'd16, 1'b0, '0},
		'{11'd8, 11'd24, 1'b0, '0},
		'{11'd8, 11'd32, 1'b0, '0},
		'{11'd1024, 11'd1024, 1'b0, '0},
		'{11'd1, 11'd1, 1'b0, '0},
		'{11'd15, 11'd31, 1'b0, '0},
		'{11'd1365, 11'd682, 1'b0, '0}
	};

	task automatic random_phase(input int count, input int max_idx);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				send_point(11'($urandom), 11'($urandom), 1'b0, '0);
			else
				send_point(11'($urandom_range(max_idx)), 11'($urandom_range(max_idx)),
					1'b0, '0);
		end
	endtask

	initial begin
		seg_reg = 11'd32;
		ring_reg = 11'd16;
		red_reg = '0;
		green_reg = '0;
		blue_reg = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_points[i])
			send_point(directed_points[i].row, directed_points[i].col,
				directed_points[i].known, directed_points[i].vx);
		drain_pipeline();

		// zero and extreme counts, unknown indexes, gradient color
		write_reg(REG_SEGMENTS, 15'd0);
		write_reg(REG_RINGS, 15'd2047);
		write_reg(3'd7, 15'h7FFF);
		write_reg(3'd5, 15'd123);
		random_phase(200, 2047);
		drain_pipeline();

		write_reg(REG_SEGMENTS, 15'd1024);
		write_reg(REG_RINGS, 15'd1);
		write_reg(REG_RED, 15'h7FFF);
		write_reg(REG_GREEN, 15'd16384);
		write_reg(REG_BLUE, 15'd0);
		random_phase(200, 1100);
		drain_pipeline();

		write_reg(REG_SEGMENTS, 15'd7);
		write_reg(REG_RINGS, 15'd5);
		write_reg(REG_RED, 15'd0);
		write_reg(REG_GREEN, 15'd0);
		write_reg(REG_BLUE, 15'd16383);
		random_phase(200, 9);
		drain_pipeline();

		write_reg(REG_BLUE, 15'd0);
		idle_enable = 1'b0;
		random_phase(300, 12);
		idle_enable = 1'b1;
		drain_pipeline();

		// several random settings, mostly small counts
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_SEGMENTS, 15'($urandom_range(p == 5 ? 2047 : 64)));
			write_reg(REG_RINGS, 15'($urandom_range(p == 5 ? 2047 : 64)));
			write_reg(REG_RED, (p % 2) ? 15'($urandom) : 15'd0);
			write_reg(REG_GREEN, (p % 3 == 0) ? 15'($urandom) : 15'd0);
			write_reg(REG_BLUE, 15'd0);
			random_phase(120, (p == 5) ? 2047 : 70);
			drain_pipeline();
		end

		$display("covered %0d vertices over %0d register writes", vertex_count, cfg_writes);
		if (mismatch_count == 0)
			$display("uv_sphere_vertex_generator_core_test: PASS");
		else
			$display("uv_sphere_vertex_generator_core_test: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("uv_sphere_vertex_generator_core_test: FAIL");
		$finish;
	end

endmodule

/* files.f */
design/uvs_pkg.sv
design/uvs_cordic.sv
design/uvs_divider.sv
design/uv_sphere_vertex_generator_core.sv
tb/uv_sphere_vertex_generator_core_test.sv
